[hw/rtl/lgbf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lgbf_pkg
// Shared types, constants and the flag-word function for the label grid
// boundary flag block.
// ----------------------------------------------------------------------------
package lgbf_pkg;

  localparam int COL_BITS     = 10;
  localparam int ROW_BITS     = 10;
  localparam int MAX_COLS     = 1 << COL_BITS;
  localparam int MAX_ROWS     = 1 << ROW_BITS;
  localparam int LABEL_BITS   = 8;
  localparam int CFG_BITS     = 11;
  localparam int CFG_IDX_BITS = 2;
  localparam int FLAG_BITS    = 5;
  localparam int RES_CNT      = 3;
  localparam int JOB_DEPTH    = 4;
  localparam int JOB_PTR_BITS = $clog2(JOB_DEPTH);

  // flag word bit positions
  localparam int FLG_LEFT   = 0;
  localparam int FLG_RIGHT  = 1;
  localparam int FLG_UP     = 2;
  localparam int FLG_DOWN   = 3;
  localparam int FLG_FILLED = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1
  } cfg_reg_t;

  // which of the up to three results of one word
  typedef enum logic [1:0] {
    RES_ABOVE = 2'd0,  // cell one row up, same column
    RES_LEFT  = 2'd1,  // last row, one column left
    RES_HERE  = 2'd2   // last row, last column, the cell itself
  } res_sel_t;

  typedef logic [LABEL_BITS-1:0] label_t;
  typedef logic [FLAG_BITS-1:0]  flags_t;

  typedef struct packed {
    logic [RES_CNT-1:0]              mask;
    logic [ROW_BITS-1:0]             row;
    logic [COL_BITS-1:0]             col;
    logic [RES_CNT-1:0][FLAG_BITS-1:0] flags;
  } job_t;

  function automatic flags_t flag_word(label_t s, label_t l, label_t r,
                                       label_t u, label_t d);
    flags_t f;
    f = '0;
    if (s != '0) begin
      f[FLG_FILLED] = 1'b1;
      f[FLG_LEFT]   = (l != s);
      f[FLG_RIGHT]  = (r != s);
      f[FLG_UP]     = (u != s);
      f[FLG_DOWN]   = (d != s);
    end
    return f;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/lgbf_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lgbf_front
// Raster position counters, the two line stores, the neighbor window and
// the stencil; each accepted word with results yields a job of up to three.
// ----------------------------------------------------------------------------
module lgbf_front
  import lgbf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire label_t                  cell_label,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_wdata,
  input  wire logic                    job_full,
  output logic                         job_push,
  output job_t                         job
);

  function automatic logic [COL_BITS-1:0] last_index(logic [CFG_BITS-1:0] v);
    if (v == '0) return '0;
    else if (v > CFG_BITS'(MAX_COLS)) return COL_BITS'(MAX_COLS - 1);
    else return COL_BITS'(v - CFG_BITS'(1));
  endfunction

  logic [COL_BITS-1:0] col_r, col_nxt, last_col_r, last_col_nxt;
  logic [ROW_BITS-1:0] row_r, row_nxt, last_row_r, last_row_nxt;

  // line stores, undefined until written
  label_t newer_mem [MAX_COLS];
  label_t older_mem [MAX_COLS];

  // window: row r-1 at c and c+1, row r-2 at c, row r-1 at c-1
  label_t nb_cur_r, nb_next_r, ol_cur_r, upleft_r;
  label_t left0_r, left1_r;
  label_t start0_r, start1_r, ostart0_r;

  logic accept, is_last_col, is_last_row, has_up, has_up2, c_gt0, c_ge2;
  logic cfg_hit;
  logic [COL_BITS-1:0] rd_addr_newer, rd_addr_older;
  label_t lf0, rt0, up0, lf1, up1, lf2, up2;

  assign accept      = push && !job_full;
  assign is_last_col = (col_r == last_col_r);
  assign is_last_row = (row_r == last_row_r);
  assign has_up      = (row_r != '0);
  assign has_up2     = (row_r[ROW_BITS-1:1] != '0);
  assign c_gt0       = (col_r != '0);
  assign c_ge2       = (col_r[COL_BITS-1:1] != '0);
  assign cfg_hit     = cfg_we && ((cfg_index == CFG_GRID_WIDTH) ||
                                  (cfg_index == CFG_GRID_HEIGHT));

  assign rd_addr_newer = col_r + COL_BITS'(2);
  assign rd_addr_older = col_r + COL_BITS'(1);

  // stencil
  always_comb begin
    lf0 = c_gt0        ? upleft_r  : nb_cur_r;
    rt0 = !is_last_col ? nb_next_r : nb_cur_r;
    up0 = has_up2      ? ol_cur_r  : nb_cur_r;
    lf1 = c_ge2        ? left1_r   : left0_r;
    up1 = has_up       ? upleft_r  : left0_r;
    lf2 = c_gt0        ? left0_r   : cell_label;
    up2 = has_up       ? nb_cur_r  : cell_label;

    job.row  = row_r;
    job.col  = col_r;
    job.mask = '0;
    job.mask[RES_ABOVE] = has_up;
    job.mask[RES_LEFT]  = is_last_row && c_gt0;
    job.mask[RES_HERE]  = is_last_row && is_last_col;
    job.flags[RES_ABOVE] = flag_word(nb_cur_r, lf0, rt0, up0, cell_label);
    job.flags[RES_LEFT]  = flag_word(left0_r, lf1, cell_label, up1, left0_r);
    job.flags[RES_HERE]  = flag_word(cell_label, lf2, cell_label, up2, cell_label);
  end

  assign job_push = accept && (job.mask != '0);

  // position and size registers
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    last_col_nxt = last_col_r;
    last_row_nxt = last_row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
      if (cfg_index == CFG_GRID_WIDTH) last_col_nxt = last_index(cfg_wdata);
      else last_row_nxt = ROW_BITS'(last_index(cfg_wdata));
    end else if (accept) begin
      if (is_last_col) begin
        col_nxt = '0;
        row_nxt = is_last_row ? '0 : row_r + ROW_BITS'(1);
      end else begin
        col_nxt = col_r + COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      last_col_r <= COL_BITS'(MAX_COLS - 1);
      last_row_r <= ROW_BITS'(MAX_ROWS - 1);
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      last_col_r <= last_col_nxt;
      last_row_r <= last_row_nxt;
    end
  end

  // line stores: at most one write and one registered read each per word
  always_ff @(posedge clk) begin
    if (accept) begin
      newer_mem[col_r] <= cell_label;
      if (has_up) older_mem[col_r] <= nb_cur_r;
      if (!is_last_col) begin
        nb_next_r <= newer_mem[rd_addr_newer];
        ol_cur_r  <= older_mem[rd_addr_older];
      end else begin
        // row start for the next row comes from the captured first columns
        nb_next_r <= (col_r == COL_BITS'(1)) ? cell_label : start1_r;
        ol_cur_r  <= c_gt0 ? ostart0_r : nb_cur_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left1_r  <= left0_r;
      left0_r  <= cell_label;
      upleft_r <= nb_cur_r;
      if (!c_gt0) begin
        start0_r  <= cell_label;
        ostart0_r <= nb_cur_r;
      end
      if (col_r == COL_BITS'(1)) start1_r <= cell_label;
      if (!is_last_col) nb_cur_r <= nb_next_r;
      else nb_cur_r <= c_gt0 ? start0_r : cell_label;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/lgbf_job_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lgbf_job_fifo
// Short job queue between the stencil front and the result back end.
// ----------------------------------------------------------------------------
module lgbf_job_fifo
  import lgbf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire job_t wr_job,
  input  wire logic rd_en,
  output logic      full,
  output logic      empty,
  output job_t      head
);

  job_t                  slots [JOB_DEPTH];
  logic [JOB_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [JOB_PTR_BITS:0]   count_r, count_nxt;
  logic do_wr, do_rd;

  assign full  = (count_r == (JOB_PTR_BITS+1)'(JOB_DEPTH));
  assign empty = (count_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign head  = slots[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    unique case ({do_wr, do_rd})
      2'b10:   count_nxt = count_r + (JOB_PTR_BITS+1)'(1);
      2'b01:   count_nxt = count_r - (JOB_PTR_BITS+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_wr) wr_ptr_r <= wr_ptr_r + JOB_PTR_BITS'(1);
      if (do_rd) rd_ptr_r <= rd_ptr_r + JOB_PTR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr_r] <= wr_job;
  end

endmodule
`default_nettype wire

[hw/rtl/lgbf_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lgbf_back
// Walks the results of the head job in order, one word per pop, and
// retires the job after its last result.
// ----------------------------------------------------------------------------
module lgbf_back
  import lgbf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire job_t                head,
  input  wire logic                job_empty,
  output logic                     job_pop,
  input  wire logic                pop,
  output logic                     empty,
  output logic [ROW_BITS-1:0]      out_row,
  output logic [COL_BITS-1:0]      out_col,
  output flags_t                   out_boundary_flags,
  output logic                     out_last_of_run
);

  logic [RES_CNT-1:0] done_r, done_nxt, avail, sel_bit;
  res_sel_t sel;
  logic fire;

  assign avail = head.mask & ~done_r;

  always_comb begin
    priority if (avail[RES_ABOVE]) sel = RES_ABOVE;
    else if (avail[RES_LEFT])      sel = RES_LEFT;
    else                           sel = RES_HERE;
  end

  assign sel_bit         = RES_CNT'(1) << sel;
  assign out_last_of_run = ((avail & ~sel_bit) == '0);
  assign empty           = job_empty;
  assign fire            = pop && !job_empty;
  assign job_pop         = fire && out_last_of_run;

  assign out_row = (sel == RES_ABOVE) ? head.row - ROW_BITS'(1) : head.row;
  assign out_col = (sel == RES_LEFT)  ? head.col - COL_BITS'(1) : head.col;
  assign out_boundary_flags = head.flags[sel];

  always_comb begin
    done_nxt = done_r;
    if (fire) done_nxt = out_last_of_run ? '0 : (done_r | sel_bit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= '0;
    else done_r <= done_nxt;
  end

endmodule
`default_nettype wire

[hw/rtl/label_grid_boundary_flags_top.sv]
`default_nettype none
// A taken word's results wait in the job queue until its job is at the head.
// Throughput: one input word per cycle; results leave at one per cycle, set
// by the single result port (last row words give up to three results each).
// The input stalls only when the four-entry job queue is full.
// Reset (synchronous, rst_n low): position restarts at row 0 column 0, queue
// empties, grid size returns to 1024 x 1024. Line stores are not cleared.
// ----------------------------------------------------------------------------
// label_grid_boundary_flags_top
// 4-neighbor boundary flags over a raster stream of cell labels.
// ----------------------------------------------------------------------------
module label_grid_boundary_flags_top
  import lgbf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // config write port; a size write restarts the frame
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_wdata,
  // input words
  input  wire logic                    push,
  output logic                         full,
  input  wire logic [LABEL_BITS-1:0]   in_cell_label,
  // result words
  output logic                         empty,
  input  wire logic                    pop,
  output logic [ROW_BITS-1:0]          out_row,
  output logic [COL_BITS-1:0]          out_col,
  output logic [FLAG_BITS-1:0]         out_boundary_flags,
  output logic                         out_last_of_run
);

  // Front: counters, line stores and stencil. Each word past row 0 finishes
  // the cell one row up (plus, on the last row, the cell to its left and the
  // row's final cell) and hands them over as one job.
  job_t job_in, job_head;
  logic job_push, job_full, job_empty, job_pop;

  assign full = job_full;

  lgbf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .cell_label (in_cell_label),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .job_full   (job_full),
    .job_push   (job_push),
    .job        (job_in)
  );

  // Jobs queue here; a stalled consumer stops the raster only once this is full.
  lgbf_job_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_push),
    .wr_job (job_in),
    .rd_en  (job_pop),
    .full   (job_full),
    .empty  (job_empty),
    .head   (job_head)
  );

  // Back: expands each job into its result words, in raster order.
  lgbf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (job_head),
    .job_empty          (job_empty),
    .job_pop            (job_pop),
    .pop                (pop),
    .empty              (empty),
    .out_row            (out_row),
    .out_col            (out_col),
    .out_boundary_flags (out_boundary_flags),
    .out_last_of_run    (out_last_of_run)
  );

endmodule
`default_nettype wire
